// ===== sv/stable_priority_queue_unit_macros.svh =====
// assertion macros for the stable priority queue unit
// no dependencies; included by the queue unit
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define SPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/spq_pkg.sv =====
// package for the stable priority queue: operation and status codes, beat types
// no dependencies
package spq_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_CHANGE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;
  } rsp_t;
endpackage

// ===== sv/spq_if.sv =====
// valid/ready channel carrying one payload beat
// depends on spq_pkg for the payload types
interface spq_req_if (input logic clk);
  logic          valid;
  logic          ready;
  spq_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if (input logic clk);
  logic          valid;
  logic          ready;
  spq_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stable_priority_queue_unit.sv =====
// Stable priority queue unit.
// req channel (sink): operation, entry_id, entry_priority; rsp channel (source):
// status, out_id, out_priority, occupancy. One response beat per request beat.
// Entries sit in one synchronous memory, front first, sorted by ascending
// priority with arrival order kept among equal priorities. Each operation is a
// sequencer walk over the memory: a scan pass reads slot k each cycle (one read
// port, registered read) to find the match or the insert point, then a shift
// pass moves the entries one at a time (read then write back). Change runs a
// remove walk and then an insert walk. The read-modify-write of the memory
// port sets the pace of each walk.
// The response sits in an output register; a stalled receiver holds it, and the
// next request is taken the cycle after the response has been taken.
// Reset (rst, synchronous) clears the count and control state; memory contents
// are left as they are and are never read beyond the count.
`include "stable_priority_queue_unit_macros.svh"
module stable_priority_queue_unit #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input logic clk,
  input logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_DROP  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  typedef struct packed {
    logic [15:0]          id;
    logic [PRIO_BITS-1:0] prio;
  } slot_t;

  slot_t mem [DEPTH];
  slot_t rd_data;
  logic  rd_en;
  logic [AW-1:0] rd_addr;
  logic  wr_en;
  logic [AW-1:0] wr_addr;
  slot_t wr_data;

  // memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // slot being read in the scan
  logic          pend;     // read data for idx-1 valid
  logic [1:0]    op;
  logic [15:0]   key_id;
  logic [PRIO_BITS-1:0] key_prio;
  logic [CW-1:0] pos;
  logic          out_valid;
  spq_pkg::rsp_t out_data;
  logic [CW-1:0] wide_ptr;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // read and write port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    wide_ptr = idx - CW'(1);
    case (state)
      S_FIND: rd_en = (idx < count);
      S_DROP: begin
        // idx walks up: read idx, write idx-1 with it
        rd_en = (idx < count);
        wr_en = pend;
        wr_addr = wide_ptr[AW-1:0];
        wr_addr = (idx - CW'(2)) < CW'(DEPTH) ? AW'(idx - CW'(2)) : AW'(0);
      end
      S_INS: begin
        // idx walks down from count: read idx-1, write idx
        rd_en = (idx > pos);
        rd_addr = wide_ptr[AW-1:0];
        wr_en = pend;
        wr_addr = AW'(idx + CW'(1));
        if (!pend && idx == pos) begin
          wr_en = 1'b1;
          wr_addr = pos[AW-1:0];
          wr_data = '{id: key_id, prio: key_prio};
        end else if (pend && idx == pos) begin
          wr_addr = AW'(pos + CW'(1));
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op       <= req.data.operation;
            key_id   <= req.data.entry_id;
            key_prio <= PRIO_BITS'(req.data.entry_priority);
            out_data <= '0;
            idx      <= '0;
            pend     <= 1'b0;
            state    <= S_FIND;
          end
        end
        S_FIND: begin
          // scan: compare the slot read last cycle
          pend <= (idx < count);
          if (idx < count) idx <= idx + CW'(1);
          if (pend && ((op == spq_pkg::OP_INSERT && rd_data.prio > key_prio) ||
                       ((op == spq_pkg::OP_REMOVE || op == spq_pkg::OP_CHANGE) &&
                        rd_data.id == key_id) ||
                       op == spq_pkg::OP_POP)) begin
            pos  <= idx - CW'(1);
            pend <= 1'b0;
            if (op == spq_pkg::OP_INSERT) begin
              // a full queue takes no insert, wherever it would land
              if (count >= CW'(DEPTH)) begin
                out_data.status <= spq_pkg::ST_FULL;
                state <= S_RESP;
              end else begin
                idx   <= count;
                state <= S_INS;
              end
            end else begin
              if (op == spq_pkg::OP_POP) begin
                out_data.out_id       <= rd_data.id;
                out_data.out_priority <= 8'(rd_data.prio);
              end
              idx   <= idx;
              state <= S_DROP;
            end
          end else if (!pend && idx >= count) begin
            // scan ran off the end
            pos <= count;
            case (op)
              spq_pkg::OP_INSERT: begin
                if (count >= CW'(DEPTH)) begin
                  out_data.status <= spq_pkg::ST_FULL;
                  state <= S_RESP;
                end else begin
                  idx   <= count;
                  state <= S_INS;
                end
              end
              spq_pkg::OP_POP: begin
                out_data.status <= spq_pkg::ST_EMPTY;
                state <= S_RESP;
              end
              default: begin
                out_data.status <= spq_pkg::ST_NOT_FOUND;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_DROP: begin
          // shift entries above the hole down by one
          pend <= (idx < count);
          if (idx < count) idx <= idx + CW'(1);
          if (!(idx < count) && !pend) begin
            count <= count - CW'(1);
            if (op == spq_pkg::OP_CHANGE) begin
              op    <= spq_pkg::OP_INSERT;
              idx   <= '0;
              state <= S_FIND;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_INS: begin
          // shift entries at or above pos up by one, then write the new one
          if (!pend && idx == pos) begin
            count <= count + CW'(1);
            state <= S_RESP;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            pend <= 1'b1;
            idx  <= idx - CW'(1);
          end
        end
        S_RESP: begin
          out_data.occupancy <= 5'(count);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPQ_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(DEPTH))
  `SPQ_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !req.ready)
  `SPQ_ASSERT_NEXT(a_resp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
  `SPQ_ASSERT_NEXT(a_resp_after_seq, state == S_RESP, rsp.valid)
endmodule

// ===== tb/spq_tb_checker.sv =====
// checker for the stable priority queue unit: tracks request and response beats,
// keeps a sorted-list model of the queue and compares every response field
// depends on spq_pkg and the spq_req_if / spq_rsp_if interfaces
module spq_tb_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  spq_req_if          req,
  spq_rsp_if          rsp,
  output int          fail_count,
  output int          pending
);
  logic [15:0]   q_ids[$];
  logic [7:0]    q_prios[$];
  spq_pkg::rsp_t due_rsp[$];

  // place an entry behind every entry of equal or lower priority
  function automatic void place(input logic [15:0] id, input logic [7:0] pr);
    int pos;
    pos = 0;
    while (pos < q_ids.size() && q_prios[pos] <= pr) pos++;
    q_ids.insert(pos, id);
    q_prios.insert(pos, pr);
  endfunction

  function automatic int find_id(input logic [15:0] id);
    for (int k = 0; k < q_ids.size(); k++)
      if (q_ids[k] == id) return k;
    return -1;
  endfunction

  // work out the response of one request and update the model
  function automatic spq_pkg::rsp_t apply_op(input spq_pkg::req_t r);
    spq_pkg::rsp_t o;
    int            pos;
    o = '0;
    o.status = spq_pkg::ST_OK;
    case (r.operation)
      spq_pkg::OP_INSERT: begin
        if (q_ids.size() >= DEPTH) o.status = spq_pkg::ST_FULL;
        else place(r.entry_id, r.entry_priority);
      end
      spq_pkg::OP_REMOVE: begin
        pos = find_id(r.entry_id);
        if (pos < 0) o.status = spq_pkg::ST_NOT_FOUND;
        else begin
          q_ids.delete(pos);
          q_prios.delete(pos);
        end
      end
      spq_pkg::OP_POP: begin
        if (q_ids.size() == 0) o.status = spq_pkg::ST_EMPTY;
        else begin
          o.out_id = q_ids.pop_front();
          o.out_priority = q_prios.pop_front();
        end
      end
      default: begin
        pos = find_id(r.entry_id);
        if (pos < 0) o.status = spq_pkg::ST_NOT_FOUND;
        else begin
          q_ids.delete(pos);
          q_prios.delete(pos);
          place(r.entry_id, r.entry_priority);
        end
      end
    endcase
    o.occupancy = 5'(q_ids.size());
    return o;
  endfunction

  assign pending = due_rsp.size();

  // watch both channels on every edge
  always @(posedge clk) begin
    spq_pkg::rsp_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (req.valid && req.ready) due_rsp.push_back(apply_op(req.data));
      if (rsp.valid && rsp.ready) begin
        if (due_rsp.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected response beat %h", rsp.data);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.data !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp st=%0d id=%h pr=%h occ=%0d got st=%0d id=%h pr=%h occ=%0d",
                       want.status, want.out_id, want.out_priority, want.occupancy,
                       rsp.data.status, rsp.data.out_id, rsp.data.out_priority,
                       rsp.data.occupancy);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// testbench top for the stable priority queue unit: clock, reset, request
// stimulus with bursts and gaps, response stalls and the verdict
// depends on spq_pkg, spq_if.sv, spq_tb_checker and the unit itself
module tb;
  localparam int DEPTH      = 16;
  localparam int N_RANDOM   = 1600;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   hold_rsp;
  int   idle_cycles;

  spq_req_if req (.clk(clk));
  spq_rsp_if rsp (.clk(clk));

  stable_priority_queue_unit #(.DEPTH(DEPTH), .PRIO_BITS(8)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  spq_tb_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // drive one request beat and wait for it to be taken
  task automatic send_beat(input logic [1:0] op, input logic [15:0] id,
                           input logic [7:0] pr);
    req.valid <= 1'b1;
    req.data  <= '{operation: op, entry_id: id, entry_priority: pr};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic gap(input int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // small id pool so remove and change hit often; sometimes a wide id
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 23));
  endfunction

  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(252, 255));
      default: return 8'($urandom());
    endcase
  endfunction

  // receiver stalls on its own pattern, with one long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (($urandom() & 32'h3f) < 8) rsp.ready <= ($urandom_range(0, 3) == 0);
      else rsp.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int burst;
    int mix;
    rst = 1'b1;
    hold_rsp = 1'b0;
    req.valid <= 1'b0;
    req.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, duplicates, fill to full
    send_beat(spq_pkg::OP_POP, 16'hffff, 8'hff);
    send_beat(spq_pkg::OP_REMOVE, 16'h0000, 8'h00);
    send_beat(spq_pkg::OP_CHANGE, 16'hffff, 8'h00);
    send_beat(spq_pkg::OP_INSERT, 16'hffff, 8'hff);
    send_beat(spq_pkg::OP_INSERT, 16'h0000, 8'h00);
    send_beat(spq_pkg::OP_INSERT, 16'h0005, 8'h80);
    send_beat(spq_pkg::OP_INSERT, 16'h0005, 8'h80);
    send_beat(spq_pkg::OP_CHANGE, 16'h0005, 8'h80);
    send_beat(spq_pkg::OP_REMOVE, 16'h0005, 8'h00);
    send_beat(spq_pkg::OP_CHANGE, 16'hffff, 8'h00);
    for (int k = 0; k < 13; k++) send_beat(spq_pkg::OP_INSERT, 16'(k + 100), 8'(k * 19));
    send_beat(spq_pkg::OP_CHANGE, 16'h0064, 8'hff);
    send_beat(spq_pkg::OP_POP, 16'h0000, 8'h00);

    // long receiver hold-off while requests keep coming
    hold_rsp = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int k = 0; k < 6; k++) send_beat(spq_pkg::OP_INSERT, pick_id(), pick_prio());
    join
    gap(0);
    // pause until every response has come
    while (pending != 0) @(posedge clk);

    // random: bursts with gaps, fixed op mix (40% insert, 20% pop, 18% remove, 22% change)
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) begin
        mix = $urandom_range(0, 99);
        if (mix < 40)      send_beat(spq_pkg::OP_INSERT, pick_id(), pick_prio());
        else if (mix < 60) send_beat(spq_pkg::OP_POP, 16'($urandom()), 8'($urandom()));
        else if (mix < 78) send_beat(spq_pkg::OP_REMOVE, pick_id(), 8'($urandom()));
        else               send_beat(spq_pkg::OP_CHANGE, pick_id(), pick_prio());
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
